/* rtl/lrsr_pkg.sv */
// ============================================================================
// lrsr_pkg
// Shared constants, codes and controller/datapath types of the LR parse engine.
// ============================================================================
package lrsr_pkg;

    localparam int NUM_STATES  = 256;
    localparam int NUM_SYMBOLS = 64;
    localparam int NUM_RULES   = 128;
    localparam int STACK_DEPTH = 64;
    localparam int MAX_RHS     = 8;
    localparam int MAX_REDUCES = 32;

    localparam int OP_W     = 3;
    localparam int STATE_W  = 8;
    localparam int SYM_W    = 6;
    localparam int KIND_W   = 3;
    localparam int TGT_W    = 8;
    localparam int RULE_W   = 7;
    localparam int POS_W    = 3;
    localparam int LEN_W    = 4;
    localparam int TAG_W    = 16;
    localparam int RES_W    = 3;
    localparam int ERR_W    = 4;
    localparam int LVL_W    = 7;
    localparam int STK_W    = $clog2(STACK_DEPTH);
    localparam int ACT_AW   = STATE_W + SYM_W;
    localparam int ACT_DW   = KIND_W + TGT_W;
    localparam int RSYM_AW  = RULE_W + POS_W;
    localparam int RED_W    = $clog2(MAX_REDUCES + 1);

    localparam logic [OP_W-1:0] OP_ACT   = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SYM   = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK  = 3'd3;
    localparam logic [OP_W-1:0] OP_START = 3'd4;
    localparam logic [OP_W-1:0] OP_TOKEN = 3'd5;

    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SHIFT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REDUCE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd4;

    localparam logic [RES_W-1:0] RES_SHIFT  = 3'd0;
    localparam logic [RES_W-1:0] RES_REDUCE = 3'd1;
    localparam logic [RES_W-1:0] RES_ACCEPT = 3'd2;
    localparam logic [RES_W-1:0] RES_ERROR  = 3'd3;
    localparam logic [RES_W-1:0] RES_IGNORE = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 4'd1;
    localparam logic [ERR_W-1:0] ERR_NO_ACTION = 4'd2;
    localparam logic [ERR_W-1:0] ERR_SHORT     = 4'd3;
    localparam logic [ERR_W-1:0] ERR_MISMATCH  = 4'd4;
    localparam logic [ERR_W-1:0] ERR_NO_GOTO   = 4'd5;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 4'd6;
    localparam logic [ERR_W-1:0] ERR_RED_LIMIT = 4'd7;
    localparam logic [ERR_W-1:0] ERR_NO_ACCEPT = 4'd8;
    localparam logic [ERR_W-1:0] ERR_KIND      = 4'd9;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_IGN, S_TLOOK, S_TDISP, S_SHIFT, S_ACC,
        S_RLEN, S_RISS, S_RCMP, S_GSEL, S_GLOOK, S_GCHK, S_ERR
    } ctrl_state_t;

    typedef enum logic [1:0] {MODE_IDLE, MODE_RUN, MODE_DONE} mode_t;

    typedef enum logic [1:0] {VAL_ZERO, VAL_ACT, VAL_RULE} val_sel_t;

    typedef struct packed {
        logic             ready;
        logic             clear;
        logic             act_rd_top;
        logic             act_rd_goto;
        logic             rule_rd;
        logic             cnt_clr;
        logic             cmp_rd;
        logic             gst_rd;
        logic             push_shift;
        logic             push_reduce;
        logic             emit;
        logic [RES_W-1:0] ev_res;
        val_sel_t         ev_val;
        logic [ERR_W-1:0] ev_err;
        logic             ev_last;
    } cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic [OP_W-1:0]   in_op;
        logic              clr_done;
        logic              known;
        logic [KIND_W-1:0] act_kind;
        logic              top_full;
        logic              red_full;
        logic              rule_oob;
        logic              len_gt_top;
        logic              len_zero;
        logic              cnt_eq_len;
        logic              sym_mismatch;
        logic              reduce_ovf;
        logic              tok_eoi;
        logic              out_free;
    } stat_t;

endpackage

/* rtl/lrsr_if.sv */
// ============================================================================
// lrsr_if
// Valid/ready channels carrying request items and parse event items.
// ============================================================================
interface lrsr_in_if;
    import lrsr_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [STATE_W-1:0]  state_index;
    logic [SYM_W-1:0]    symbol;
    logic [KIND_W-1:0]   action_kind;
    logic [TGT_W-1:0]    action_target;
    logic [RULE_W-1:0]   rule_index;
    logic [POS_W-1:0]    rhs_position;
    logic [LEN_W-1:0]    rhs_length;
    logic                known_flag;
    logic [TAG_W-1:0]    token_tag;
    logic                end_of_input;

    modport source (output valid, opcode, state_index, symbol, action_kind, action_target,
                    rule_index, rhs_position, rhs_length, known_flag, token_tag,
                    end_of_input, input ready);
    modport sink (input valid, opcode, state_index, symbol, action_kind, action_target,
                  rule_index, rhs_position, rhs_length, known_flag, token_tag,
                  end_of_input, output ready);
endinterface

interface lrsr_out_if;
    import lrsr_pkg::*;
    logic               valid;
    logic               ready;
    logic [RES_W-1:0]   event_res;
    logic [TGT_W-1:0]   event_value;
    logic [ERR_W-1:0]   error_code;
    logic [TAG_W-1:0]   echoed_tag;
    logic [LVL_W-1:0]   stack_level;
    logic               last;

    modport source (output valid, event_res, event_value, error_code, echoed_tag,
                    stack_level, last, input ready);
    modport sink (input valid, event_res, event_value, error_code, echoed_tag,
                  stack_level, last, output ready);
endinterface

/* rtl/lr_shift_reduce_parser_core.sv */
// ============================================================================
// lr_shift_reduce_parser_core
// Table-driven LR shift-reduce parse engine, one event item per shift,
// reduce, accept, error or ignored token.
// ============================================================================
// After reset the block sweeps the action table to "none", one entry a cycle,
// and takes no item until the sweep ends. Table loads and starts are then
// taken in the idle state. A token that shifts passes the lookup, dispatch
// and shift states; each reduce before it adds a rule read, a walk that
// compares the right side with the stack memory one entry a cycle, a read of
// the state under it and a goto lookup. An event waiting in the output
// register holds the engine only when the next event is due.
module lr_shift_reduce_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    lrsr_in_if.sink    in_ch,
    lrsr_out_if.source out_ch
);
    import lrsr_pkg::*;

    cmd_t  cmd;
    stat_t st;

    lrsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    lrsr_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .st     (st)
    );

endmodule

/* rtl/lrsr_ctrl.sv */
// ============================================================================
// lrsr_ctrl
// Parse sequencer: token dispatch, reduce walk, goto and event issue.
// ============================================================================
module lrsr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  lrsr_pkg::stat_t st,
    output lrsr_pkg::cmd_t  cmd
);
    import lrsr_pkg::*;

    ctrl_state_t      state_reg, state_next;
    mode_t            mode_reg, mode_next;
    logic [ERR_W-1:0] err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            mode_reg  <= MODE_IDLE;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.ev_val = VAL_ZERO;
        state_next = state_reg;
        mode_next  = mode_reg;
        err_next   = err_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (st.in_valid)
                begin
                    case (st.in_op)
                        OP_START: mode_next = MODE_RUN;
                        OP_TOKEN: state_next = (mode_reg == MODE_RUN) ? S_TLOOK : S_IGN;
                        default: ;
                    endcase
                end
            end
            S_IGN:
            begin
                if (st.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.ev_res  = RES_IGNORE;
                    cmd.ev_last = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TLOOK:
            begin
                if (!st.known)
                begin
                    err_next   = ERR_UNKNOWN;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.act_rd_top = 1'b1;
                    state_next     = S_TDISP;
                end
            end
            S_TDISP:
            begin
                state_next = S_ERR;
                case (st.act_kind)
                    KIND_NONE: err_next = ERR_NO_ACTION;
                    KIND_SHIFT:
                    begin
                        if (st.top_full)
                            err_next = ERR_OVERFLOW;
                        else
                            state_next = S_SHIFT;
                    end
                    KIND_ACCEPT: state_next = S_ACC;
                    KIND_REDUCE:
                    begin
                        if (st.red_full)
                            err_next = ERR_RED_LIMIT;
                        else if (st.rule_oob)
                            err_next = ERR_MISMATCH;
                        else
                        begin
                            cmd.rule_rd = 1'b1;
                            state_next  = S_RLEN;
                        end
                    end
                    default: err_next = ERR_KIND;
                endcase
            end
            S_SHIFT:
            begin
                if (st.out_free)
                begin
                    cmd.push_shift = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.ev_res     = RES_SHIFT;
                    cmd.ev_val     = VAL_ACT;
                    cmd.ev_last    = !st.tok_eoi;
                    if (st.tok_eoi)
                    begin
                        err_next   = ERR_NO_ACCEPT;
                        state_next = S_ERR;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_ACC:
            begin
                if (st.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.ev_res  = RES_ACCEPT;
                    cmd.ev_val  = VAL_ACT;
                    cmd.ev_last = 1'b1;
                    mode_next   = MODE_DONE;
                    state_next  = S_IDLE;
                end
            end
            S_RLEN:
            begin
                if (st.len_gt_top)
                begin
                    err_next   = ERR_SHORT;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = st.len_zero ? S_GSEL : S_RISS;
                end
            end
            S_RISS:
            begin
                cmd.cmp_rd = 1'b1;
                state_next = S_RCMP;
            end
            S_RCMP:
            begin
                if (st.sym_mismatch)
                begin
                    err_next   = ERR_MISMATCH;
                    state_next = S_ERR;
                end
                else if (st.cnt_eq_len)
                    state_next = S_GSEL;
                else
                    cmd.cmp_rd = 1'b1;
            end
            S_GSEL:
            begin
                cmd.gst_rd = 1'b1;
                state_next = S_GLOOK;
            end
            S_GLOOK:
            begin
                cmd.act_rd_goto = 1'b1;
                state_next      = S_GCHK;
            end
            S_GCHK:
            begin
                if (st.act_kind != KIND_GOTO)
                begin
                    err_next   = ERR_NO_GOTO;
                    state_next = S_ERR;
                end
                else if (st.reduce_ovf)
                begin
                    err_next   = ERR_OVERFLOW;
                    state_next = S_ERR;
                end
                else if (st.out_free)
                begin
                    cmd.push_reduce = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.ev_res      = RES_REDUCE;
                    cmd.ev_val      = VAL_RULE;
                    state_next      = S_TLOOK;
                end
            end
            S_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.ev_res  = RES_ERROR;
                    cmd.ev_err  = err_reg;
                    cmd.ev_last = 1'b1;
                    mode_next   = MODE_DONE;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free) else $error("event issued into a full output register");
    a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_shift |-> !st.top_full) else $error("shift past stack depth");
    a_reduce_goto: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_reduce |-> (st.act_kind == KIND_GOTO && !st.reduce_ovf))
        else $error("reduce push without a valid goto");
    a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RCMP && cmd.cmp_rd) |-> !st.cnt_eq_len)
        else $error("compare walk ran past the right side");

endmodule

/* rtl/lrsr_dp.sv */
// ============================================================================
// lrsr_dp
// Parse datapath: tables, parse stack, token registers and event register.
// ============================================================================
module lrsr_dp (
    input  logic            clk,
    input  logic            rst_n,
    lrsr_in_if.sink         in_ch,
    lrsr_out_if.source      out_ch,
    input  lrsr_pkg::cmd_t  cmd,
    output lrsr_pkg::stat_t st
);
    import lrsr_pkg::*;

    logic [ACT_DW-1:0]  act_mem [2**ACT_AW];
    logic [SYM_W-1:0]   head_mem [2**RULE_W];
    logic [LEN_W-1:0]   len_mem [2**RULE_W];
    logic [SYM_W-1:0]   rsym_mem [2**RSYM_AW];
    logic [STATE_W-1:0] sst_mem [STACK_DEPTH];
    logic [SYM_W-1:0]   ssym_mem [STACK_DEPTH];

    logic [ACT_AW:0]     clr_cnt_reg;
    logic [NUM_SYMBOLS-1:0] known_reg;
    logic [ACT_DW-1:0]   act_rd_reg;
    logic [SYM_W-1:0]    head_rd_reg;
    logic [LEN_W-1:0]    len_rd_reg;
    logic [SYM_W-1:0]    rsym_rd_reg;
    logic [STATE_W-1:0]  sst_rd_reg;
    logic [SYM_W-1:0]    ssym_rd_reg;
    logic [STK_W-1:0]    top_reg, top_next;
    logic [STATE_W-1:0]  top_state_reg;
    logic [SYM_W-1:0]    tok_sym_reg;
    logic [TAG_W-1:0]    tok_tag_reg;
    logic                tok_eoi_reg;
    logic [RED_W-1:0]    red_cnt_reg;
    logic [RULE_W-1:0]   rule_reg;
    logic [LEN_W-1:0]    cnt_reg;

    logic                out_valid_reg;
    logic [RES_W-1:0]    out_res_reg;
    logic [TGT_W-1:0]    out_val_reg;
    logic [ERR_W-1:0]    out_err_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [LVL_W-1:0]    out_lvl_reg;
    logic                out_last_reg;

    logic                accept;
    logic                act_we, act_re;
    logic [ACT_AW-1:0]   act_waddr, act_raddr;
    logic [ACT_DW-1:0]   act_wdata;
    logic [KIND_W-1:0]   act_kind;
    logic [TGT_W-1:0]    act_tgt;
    logic [LVL_W-1:0]    lvl_top, lvl_len, lvl_under, lvl_base, lvl_cmp;
    logic                stk_we;
    logic [STK_W-1:0]    stk_waddr;
    logic [STATE_W-1:0]  stk_wstate;
    logic [SYM_W-1:0]    stk_wsym;
    logic [LEN_W-1:0]    len_sat;
    logic [TGT_W-1:0]    ev_val;

    assign accept   = in_ch.valid && cmd.ready;
    assign in_ch.ready = cmd.ready;
    assign act_kind = act_rd_reg[ACT_DW-1:TGT_W];
    assign act_tgt  = act_rd_reg[TGT_W-1:0];

    assign lvl_top   = LVL_W'(top_reg);
    assign lvl_len   = LVL_W'(len_rd_reg);
    assign lvl_under = lvl_top - lvl_len;
    assign lvl_base  = lvl_under + LVL_W'(1);
    assign lvl_cmp   = lvl_base + LVL_W'(cnt_reg);

    // action table: one write port shared by the clearing sweep and loads
    always_comb
    begin
        act_we    = 1'b0;
        act_waddr = {in_ch.state_index, in_ch.symbol};
        act_wdata = {in_ch.action_kind, in_ch.action_target};
        if (cmd.clear)
        begin
            act_we    = !clr_cnt_reg[ACT_AW];
            act_waddr = clr_cnt_reg[ACT_AW-1:0];
            act_wdata = '0;
        end
        else if (accept && in_ch.opcode == OP_ACT)
            act_we = 1'b1;
        act_re    = cmd.act_rd_top || cmd.act_rd_goto;
        act_raddr = cmd.act_rd_goto ? {sst_rd_reg, head_rd_reg} : {top_state_reg, tok_sym_reg};
    end

    always_ff @(posedge clk)
    begin
        if (act_we)
            act_mem[act_waddr] <= act_wdata;
        if (act_re)
            act_rd_reg <= act_mem[act_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear && !clr_cnt_reg[ACT_AW])
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            known_reg <= '0;
        else if (accept && in_ch.opcode == OP_MARK)
            known_reg[in_ch.symbol] <= in_ch.known_flag;
    end

    // rule tables
    assign len_sat = (in_ch.rhs_length > LEN_W'(MAX_RHS)) ? LEN_W'(MAX_RHS) : in_ch.rhs_length;

    always_ff @(posedge clk)
    begin
        if (accept && in_ch.opcode == OP_HEAD)
        begin
            head_mem[in_ch.rule_index] <= in_ch.symbol;
            len_mem[in_ch.rule_index]  <= len_sat;
        end
        if (cmd.rule_rd)
        begin
            head_rd_reg <= head_mem[act_tgt[RULE_W-1:0]];
            len_rd_reg  <= len_mem[act_tgt[RULE_W-1:0]];
            rule_reg    <= act_tgt[RULE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_ch.opcode == OP_SYM)
            rsym_mem[{in_ch.rule_index, in_ch.rhs_position}] <= in_ch.symbol;
        if (cmd.cmp_rd)
            rsym_rd_reg <= rsym_mem[{rule_reg, cnt_reg[POS_W-1:0]}];
    end

    // parse stack
    always_comb
    begin
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wstate = '0;
        stk_wsym   = '0;
        top_next   = top_reg;
        if (accept && in_ch.opcode == OP_START)
        begin
            stk_we   = 1'b1;
            top_next = '0;
        end
        else if (cmd.push_shift)
        begin
            stk_we     = 1'b1;
            top_next   = top_reg + 1'b1;
            stk_waddr  = top_next;
            stk_wstate = act_tgt;
            stk_wsym   = tok_sym_reg;
        end
        else if (cmd.push_reduce)
        begin
            stk_we     = 1'b1;
            top_next   = lvl_base[STK_W-1:0];
            stk_waddr  = top_next;
            stk_wstate = act_tgt;
            stk_wsym   = head_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            sst_mem[stk_waddr] <= stk_wstate;
        if (cmd.gst_rd)
            sst_rd_reg <= sst_mem[lvl_under[STK_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            ssym_mem[stk_waddr] <= stk_wsym;
        if (cmd.cmp_rd)
            ssym_rd_reg <= ssym_mem[lvl_cmp[STK_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            top_state_reg <= '0;
        end
        else if (stk_we)
        begin
            top_reg       <= top_next;
            top_state_reg <= stk_wstate;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (accept && in_ch.opcode == OP_TOKEN)
                red_cnt_reg <= '0;
            else if (cmd.push_reduce)
                red_cnt_reg <= red_cnt_reg + 1'b1;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cmp_rd)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_ch.opcode == OP_TOKEN)
        begin
            tok_sym_reg <= in_ch.symbol;
            tok_tag_reg <= in_ch.token_tag;
            tok_eoi_reg <= in_ch.end_of_input;
        end
    end

    // event register
    always_comb
    begin
        case (cmd.ev_val)
            VAL_ACT:  ev_val = act_tgt;
            VAL_RULE: ev_val = TGT_W'(rule_reg);
            default:  ev_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_res_reg  <= cmd.ev_res;
            out_val_reg  <= ev_val;
            out_err_reg  <= cmd.ev_err;
            out_tag_reg  <= tok_tag_reg;
            out_lvl_reg  <= LVL_W'(top_next);
            out_last_reg <= cmd.ev_last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.event_res   = out_res_reg;
    assign out_ch.event_value = out_val_reg;
    assign out_ch.error_code  = out_err_reg;
    assign out_ch.echoed_tag  = out_tag_reg;
    assign out_ch.stack_level = out_lvl_reg;
    assign out_ch.last        = out_last_reg;

    always_comb
    begin
        st.in_valid     = in_ch.valid;
        st.in_op        = in_ch.opcode;
        st.clr_done     = clr_cnt_reg[ACT_AW];
        st.known        = known_reg[tok_sym_reg];
        st.act_kind     = act_kind;
        st.top_full     = (lvl_top + LVL_W'(1)) >= LVL_W'(STACK_DEPTH);
        st.red_full     = red_cnt_reg >= RED_W'(MAX_REDUCES);
        st.rule_oob     = {1'b0, act_tgt} >= (TGT_W+1)'(NUM_RULES);
        st.len_gt_top   = lvl_len > lvl_top;
        st.len_zero     = (len_rd_reg == '0);
        st.cnt_eq_len   = (cnt_reg == len_rd_reg);
        st.sym_mismatch = (ssym_rd_reg != rsym_rd_reg);
        st.reduce_ovf   = lvl_base >= LVL_W'(STACK_DEPTH);
        st.tok_eoi      = tok_eoi_reg;
        st.out_free     = !out_valid_reg || out_ch.ready;
    end

endmodule
